// File: hdl/sdspi_pkg.sv
// Package: types, constants and helpers shared by the SD SPI command engine.
package sdspi_pkg;

    localparam int BlockBytesDefault = 512;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_DESEL    = 5'd1,
        PH_SELDUMMY = 5'd2,
        PH_SELPOLL  = 5'd3,
        PH_SELFAIL  = 5'd4,
        PH_FRAME    = 5'd5,
        PH_STUFF    = 5'd6,
        PH_RESP     = 5'd7,
        PH_TOKEN    = 5'd8,
        PH_DATA     = 5'd9,
        PH_CRC1     = 5'd10,
        PH_CRC2     = 5'd11,
        PH_INITCLK  = 5'd12,
        PH_R7       = 5'd13,
        PH_FINISH   = 5'd14
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_READ = 2'd1,
        KIND_INIT = 2'd2
    } kind_t;

    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;
    localparam logic [1:0] OP_XCHG = 2'd3;

    localparam logic [2:0] REG_SELECT = 3'd0;
    localparam logic [2:0] REG_TOKEN  = 3'd1;
    localparam logic [2:0] REG_RESP   = 3'd2;
    localparam logic [2:0] REG_IDLE   = 3'd3;
    localparam logic [2:0] REG_READY  = 3'd4;
    localparam logic [2:0] REG_INITDV = 3'd5;
    localparam logic [2:0] REG_RUNDV  = 3'd6;

    localparam logic [7:0] CMD_GO_IDLE  = 8'd0;
    localparam logic [7:0] CMD_IF_COND  = 8'd8;
    localparam logic [7:0] CMD_STOP     = 8'd12;
    localparam logic [7:0] CMD_READ1    = 8'd17;
    localparam logic [7:0] CMD_READN    = 8'd18;
    localparam logic [7:0] CMD_APP      = 8'd55;
    localparam logic [7:0] CMD_ACMD41   = 8'h80 | 8'd41;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] mosi;
        logic       cs_low;
        logic       data_valid;
        logic [7:0] data;
        logic       last_of_block;
        logic       done_res;
        logic [7:0] response;
        logic       ok;
        logic [8:0] divider;
    } result_t;

    function automatic logic [8:0] clamp_div(input logic [8:0] v);
        if (v < 9'd2)
            return 9'd2;
        if (v > 9'd256)
            return 9'd256;
        return v;
    endfunction

endpackage

// File: hdl/sdspi_if.sv
// Interfaces: valid/ready channels for requests and results.
interface sdspi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  cmd;
    logic [31:0] arg;
    logic [15:0] count;
    logic [7:0]  miso;
    modport source (output valid, opcode, cmd, arg, count, miso, input ready);
    modport sink   (input valid, opcode, cmd, arg, count, miso, output ready);
endinterface

interface sdspi_res_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  mosi;
    logic        cs_low;
    logic        data_valid;
    logic [7:0]  data;
    logic        last_of_block;
    logic        done_res;
    logic [7:0]  response;
    logic        ok;
    logic [8:0]  divider;
    modport source (output valid, send_valid, mosi, cs_low, data_valid, data, last_of_block,
                    done_res, response, ok, divider, input ready);
    modport sink   (input valid, send_valid, mosi, cs_low, data_valid, data, last_of_block,
                    done_res, response, ok, divider, output ready);
endinterface

// File: hdl/sd_spi_command_engine.sv
// Top level: SD card SPI-mode host command sequencer.
// One request transaction goes in per SPI byte exchange (or per new request) and one result
// transaction comes out for each. The sequencer state is updated in the same cycle as the
// transaction is accepted, and the result sits in an output register, so a transaction is
// taken every clock while the result side keeps up; with a two-entry output buffer the
// input stalls only when both entries are full. In use the rate is set by the SPI shifter:
// one transaction per byte. Requests arriving while a sequence runs are ignored; exchange
// notices (opcode 3) arriving while idle are ignored. Timeouts are counted in byte attempts.
// Read data leaves on data/data_valid with last_of_block on the final byte of each block;
// done_res closes every request.
module sd_spi_command_engine #(
    parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    sdspi_req_if.sink   req,
    sdspi_res_if.source res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    import sdspi_pkg::*;

    localparam int BcW = $clog2(BLOCK_BYTES + 1);

    // configuration registers
    logic [15:0] sel_tries_reg, idle_tries_reg, ready_tries_reg;
    logic [16:0] tok_tries_reg;
    logic [7:0]  resp_tries_reg;
    logic [8:0]  init_div_reg, run_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_tries_reg   <= 16'd500;
            tok_tries_reg   <= 17'd100000;
            resp_tries_reg  <= 8'd10;
            idle_tries_reg  <= 16'd1000;
            ready_tries_reg <= 16'd1000;
            init_div_reg    <= 9'd251;
            run_div_reg     <= 9'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELECT: sel_tries_reg   <= cfg_wdata[15:0];
                REG_TOKEN:  tok_tries_reg   <= cfg_wdata;
                REG_RESP:   resp_tries_reg  <= cfg_wdata[7:0];
                REG_IDLE:   idle_tries_reg  <= cfg_wdata[15:0];
                REG_READY:  ready_tries_reg <= cfg_wdata[15:0];
                REG_INITDV: init_div_reg    <= cfg_wdata[8:0];
                REG_RUNDV:  run_div_reg     <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    phase_t       phase_reg, phase_next;
    kind_t        kind_reg, kind_next;
    logic [7:0]   ccmd_reg, ccmd_next;
    logic [31:0]  sarg_reg, sarg_next;
    logic [2:0]   fidx_reg, fidx_next;
    logic [16:0]  try_reg, try_next;
    logic [15:0]  outer_reg, outer_next;
    logic [BcW-1:0] bcnt_reg, bcnt_next;
    logic [15:0]  blk_reg, blk_next;
    logic [7:0]   lresp_reg, lresp_next;
    logic         cs_reg, cs_next;
    logic [8:0]   div_reg, div_next;
    result_t      r;

    // two-entry output buffer
    result_t      buf0_reg, buf1_reg;
    logic [1:0]   fill_reg;
    logic         take, give;

    assign req.ready = (fill_reg != 2'd2);
    assign take      = req.valid && req.ready;
    assign give      = res.valid && res.ready;

    // The sequencing is written as chained actions on the next-state variables, in the
    // same nesting as the protocol: each action may fall through into the next one.
    logic [7:0]  eff;
    logic [7:0]  fb;
    logic [31:0] fa;
    logic        go_on;
    logic [7:0]  rv;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        ccmd_next  = ccmd_reg;
        sarg_next  = sarg_reg;
        fidx_next  = fidx_reg;
        try_next   = try_reg;
        outer_next = outer_reg;
        bcnt_next  = bcnt_reg;
        blk_next   = blk_reg;
        lresp_next = lresp_reg;
        cs_next    = cs_reg;
        div_next   = div_reg;
        r          = '0;
        eff = '0; fb = '0; fa = '0; go_on = 1'b0; rv = '0;

        // begin-request / exchange dispatch, expressed with flags
        begin : seq
            logic do_cmd_begin, do_finish, do_after, do_cmd_return, do_resp, do_token,
                  do_frame, do_acmd41, do_initclk;
            do_cmd_begin = 1'b0; do_finish = 1'b0; do_after = 1'b0; do_cmd_return = 1'b0;
            do_resp = 1'b0; do_token = 1'b0; do_frame = 1'b0; do_acmd41 = 1'b0;
            do_initclk = 1'b0;

            if (phase_reg == PH_IDLE)
            begin
                case (req.opcode)
                    OP_CMD:
                    begin
                        kind_next = KIND_CMD; ccmd_next = req.cmd; sarg_next = req.arg;
                        do_cmd_begin = 1'b1;
                    end
                    OP_READ:
                    begin
                        kind_next = KIND_READ; blk_next = req.count;
                        ccmd_next = (req.count > 16'd1) ? CMD_READN : CMD_READ1;
                        sarg_next = req.arg; do_cmd_begin = 1'b1;
                    end
                    OP_INIT:
                    begin
                        kind_next = KIND_INIT; div_next = clamp_div(init_div_reg);
                        blk_next = 16'd1; lresp_next = BYTE_IDLE;
                        outer_next = idle_tries_reg;
                        if (idle_tries_reg == 16'd0) do_finish = 1'b1;
                        else do_initclk = 1'b1;
                    end
                    default: ;
                endcase
            end
            else if (req.opcode == OP_XCHG)
            begin
                case (phase_reg)
                    PH_DESEL:
                    begin
                        cs_next = 1'b1; phase_next = PH_SELDUMMY;
                        r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                    end
                    PH_SELDUMMY:
                    begin
                        r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        if (sel_tries_reg == 16'd0)
                        begin
                            cs_next = 1'b0; phase_next = PH_SELFAIL;
                        end
                        else
                        begin
                            try_next = {1'b0, sel_tries_reg}; phase_next = PH_SELPOLL;
                        end
                    end
                    PH_SELPOLL:
                    begin
                        if (req.miso == BYTE_IDLE) do_frame = 1'b1;
                        else
                        begin
                            try_next = try_reg - 17'd1;
                            r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                            if (try_next == 17'd0)
                            begin
                                cs_next = 1'b0; phase_next = PH_SELFAIL;
                            end
                            else phase_next = PH_SELPOLL;
                        end
                    end
                    PH_SELFAIL:
                    begin
                        rv = BYTE_IDLE; do_cmd_return = 1'b1;
                    end
                    PH_FRAME:
                    begin
                        fidx_next = fidx_reg + 3'd1;
                        if (fidx_next < 3'd6)
                        begin
                            phase_next = PH_FRAME; r.send_valid = 1'b1;
                        end
                        else if (!ccmd_reg[7] && ccmd_reg[6:0] == CMD_STOP[6:0])
                        begin
                            phase_next = PH_STUFF; r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        end
                        else do_resp = 1'b1;
                    end
                    PH_STUFF: do_resp = 1'b1;
                    PH_RESP:
                    begin
                        try_next = try_reg - 17'd1;
                        if (!req.miso[7] || try_next == 17'd0)
                        begin
                            rv = req.miso; do_cmd_return = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RESP; r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (req.miso == TOKEN_DATA)
                        begin
                            bcnt_next = '0; phase_next = PH_DATA;
                            r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        end
                        else
                        begin
                            try_next = try_reg - 17'd1;
                            if (try_next == 17'd0) do_after = 1'b1;
                            else
                            begin
                                phase_next = PH_TOKEN; r.send_valid = 1'b1;
                                r.mosi = BYTE_IDLE;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        r.data_valid = 1'b1; r.data = req.miso;
                        bcnt_next = bcnt_reg + 1'b1;
                        r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        if (bcnt_next >= BcW'(BLOCK_BYTES))
                        begin
                            r.last_of_block = 1'b1; phase_next = PH_CRC1;
                        end
                        else phase_next = PH_DATA;
                    end
                    PH_CRC1:
                    begin
                        phase_next = PH_CRC2; r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                    end
                    PH_CRC2:
                    begin
                        blk_next = blk_reg - 16'd1;
                        if (blk_next == 16'd0) do_after = 1'b1;
                        else do_token = 1'b1;
                    end
                    PH_INITCLK:
                    begin
                        bcnt_next = bcnt_reg + 1'b1;
                        if (bcnt_next < BcW'(10))
                        begin
                            phase_next = PH_INITCLK; r.send_valid = 1'b1;
                            r.mosi = BYTE_IDLE;
                        end
                        else
                        begin
                            cs_next = 1'b1; ccmd_next = CMD_GO_IDLE; sarg_next = '0;
                            do_cmd_begin = 1'b1;
                        end
                    end
                    PH_R7:
                    begin
                        bcnt_next = bcnt_reg + 1'b1;
                        if (bcnt_next < BcW'(4))
                        begin
                            phase_next = PH_R7; r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        end
                        else
                        begin
                            outer_next = ready_tries_reg;
                            if (ready_tries_reg == 16'd0) do_finish = 1'b1;
                            else do_acmd41 = 1'b1;
                        end
                    end
                    PH_FINISH:
                    begin
                        phase_next = PH_IDLE; r.done_res = 1'b1; r.response = lresp_reg;
                        if (kind_reg == KIND_READ)
                            r.ok = (blk_reg == 16'd0) && (lresp_reg == 8'd0);
                        else
                            r.ok = (blk_reg == 16'd0);
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end

            // response wait start (may resolve at once to a command return)
            if (do_resp)
            begin
                if (resp_tries_reg == 8'd0)
                begin
                    rv = BYTE_IDLE; do_cmd_return = 1'b1;
                end
                else
                begin
                    try_next = {9'd0, resp_tries_reg}; phase_next = PH_RESP;
                    r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                end
            end

            // command return and caller continuation
            if (do_cmd_return)
            begin
                lresp_next = rv;
                if (ccmd_reg[7] && rv <= 8'd1)
                begin
                    ccmd_next = {1'b0, ccmd_reg[6:0]}; do_cmd_begin = 1'b1;
                end
                else if (kind_reg == KIND_READ)
                begin
                    if (ccmd_reg == CMD_STOP)
                    begin
                        lresp_next = 8'd0; do_finish = 1'b1;
                    end
                    else if (rv != 8'd0) do_finish = 1'b1;
                    else if (blk_reg == 16'd0) do_after = 1'b1;
                    else do_token = 1'b1;
                end
                else if (kind_reg == KIND_INIT)
                begin
                    if (ccmd_reg[6:0] == CMD_GO_IDLE[6:0])
                    begin
                        if (rv == 8'd1)
                        begin
                            ccmd_next = CMD_IF_COND; sarg_next = ARG_IF_COND;
                            do_cmd_begin = 1'b1;
                        end
                        else
                        begin
                            outer_next = outer_reg - 16'd1;
                            if (outer_next == 16'd0) do_finish = 1'b1;
                            else do_initclk = 1'b1;
                        end
                    end
                    else if (ccmd_reg[6:0] == CMD_IF_COND[6:0])
                    begin
                        if (rv != 8'd1) do_finish = 1'b1;
                        else
                        begin
                            bcnt_next = '0; phase_next = PH_R7;
                            r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                        end
                    end
                    else if (rv == 8'd0)
                    begin
                        div_next = clamp_div(run_div_reg); blk_next = 16'd0;
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        outer_next = outer_reg - 16'd1;
                        if (outer_next == 16'd0) do_finish = 1'b1;
                        else do_acmd41 = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE; r.done_res = 1'b1; r.response = rv;
                    r.ok = !rv[7];
                end
            end

            // token wait start (zero tries falls through to end of blocks)
            if (do_token)
            begin
                if (tok_tries_reg == 17'd0) do_after = 1'b1;
                else
                begin
                    try_next = tok_tries_reg; phase_next = PH_TOKEN;
                    r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                end
            end

            if (do_after)
            begin
                if (ccmd_reg == CMD_READN)
                begin
                    ccmd_next = CMD_STOP; sarg_next = '0; do_cmd_begin = 1'b1;
                end
                else do_finish = 1'b1;
            end

            if (do_acmd41)
            begin
                ccmd_next = CMD_ACMD41; sarg_next = ARG_HCS; do_cmd_begin = 1'b1;
            end

            if (do_initclk)
            begin
                cs_next = 1'b0; bcnt_next = '0; phase_next = PH_INITCLK;
                r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
            end

            if (do_cmd_begin)
            begin
                eff = ccmd_next[7] ? CMD_APP : {1'b0, ccmd_next[6:0]};
                if (eff != CMD_STOP && eff != CMD_GO_IDLE)
                begin
                    cs_next = 1'b0; phase_next = PH_DESEL;
                    r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
                end
                else do_frame = 1'b1;
            end

            if (do_frame)
            begin
                fidx_next = '0; phase_next = PH_FRAME; r.send_valid = 1'b1;
            end

            if (do_finish)
            begin
                cs_next = 1'b0; phase_next = PH_FINISH;
                r.send_valid = 1'b1; r.mosi = BYTE_IDLE;
            end

            // command frame byte for the current frame position
            if (phase_next == PH_FRAME && r.send_valid)
            begin
                eff = ccmd_next[7] ? CMD_APP : {1'b0, ccmd_next[6:0]};
                fa  = ccmd_next[7] ? 32'd0 : sarg_next;
                case (fidx_next)
                    3'd0: fb = 8'h40 | eff;
                    3'd1: fb = fa[31:24];
                    3'd2: fb = fa[23:16];
                    3'd3: fb = fa[15:8];
                    3'd4: fb = fa[7:0];
                    default: fb = (eff == CMD_GO_IDLE) ? 8'h95 :
                                  (eff == CMD_IF_COND) ? 8'h87 : 8'h01;
                endcase
                r.mosi = fb;
            end
            go_on = 1'b1;
        end

        r.cs_low  = cs_next;
        r.divider = div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_CMD;
            ccmd_reg  <= '0;
            sarg_reg  <= '0;
            fidx_reg  <= '0;
            try_reg   <= '0;
            outer_reg <= '0;
            bcnt_reg  <= '0;
            blk_reg   <= '0;
            lresp_reg <= BYTE_IDLE;
            cs_reg    <= 1'b0;
            div_reg   <= 9'd251;
        end
        else if (take && go_on)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            ccmd_reg  <= ccmd_next;
            sarg_reg  <= sarg_next;
            fidx_reg  <= fidx_next;
            try_reg   <= try_next;
            outer_reg <= outer_next;
            bcnt_reg  <= bcnt_next;
            blk_reg   <= blk_next;
            lresp_reg <= lresp_next;
            cs_reg    <= cs_next;
            div_reg   <= div_next;
        end
    end

    // result buffer: entry 0 is the head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_reg + {1'b0, take} - {1'b0, give};
    end

    always_ff @(posedge clk)
    begin
        if (give)
        begin
            buf0_reg <= (fill_reg == 2'd2) ? buf1_reg : r;
            if (take && fill_reg == 2'd2) buf1_reg <= r;
        end
        else if (take)
        begin
            if (fill_reg == 2'd0) buf0_reg <= r;
            else buf1_reg <= r;
        end
    end

    assign res.valid         = (fill_reg != 2'd0);
    assign res.send_valid    = buf0_reg.send_valid;
    assign res.mosi          = buf0_reg.mosi;
    assign res.cs_low        = buf0_reg.cs_low;
    assign res.data_valid    = buf0_reg.data_valid;
    assign res.data          = buf0_reg.data;
    assign res.last_of_block = buf0_reg.last_of_block;
    assign res.done_res      = buf0_reg.done_res;
    assign res.response      = buf0_reg.response;
    assign res.ok            = buf0_reg.ok;
    assign res.divider       = buf0_reg.divider;

    // buffer never overfills
    a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("result buffer overflow");
    // done is only reported when the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && r.done_res) |=> phase_reg == PH_IDLE)
        else $error("done without idle");
    // block byte counter stays inside the block
    a_bcnt: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bcnt_reg < BcW'(BLOCK_BYTES))
        else $error("block byte counter overrun");

endmodule

// File: tb/sv/sdspi_result_checker.sv
// Checker: predicts each result transaction of the SD SPI command engine and compares it.
module sdspi_result_checker
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = BlockBytesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    sdspi_req_if        req,
    sdspi_res_if        res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    output int          mismatches,
    output int          pending
);

    // register copies
    logic [15:0] sel_limit;
    logic [16:0] tok_limit;
    logic [7:0]  r1_limit;
    logic [15:0] idle_limit;
    logic [15:0] ready_limit;
    logic [8:0]  init_div;
    logic [8:0]  run_div;

    // sequencer copy
    phase_t      ph;
    kind_t       kind;
    logic [7:0]  cur_cmd;
    logic [31:0] cur_arg;
    logic [2:0]  frame_pos;
    logic [16:0] tries_left;
    logic [15:0] outer_left;
    logic [9:0]  byte_pos;
    logic [15:0] blocks_left;
    logic [7:0]  last_r1;
    logic        selected;
    logic [8:0]  div_now;

    result_t     nxt;
    result_t     expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [8:0] div_bound(input logic [8:0] v);
        return (v < 9'd2) ? 9'd2 : ((v > 9'd256) ? 9'd256 : v);
    endfunction

    function void issue(input phase_t p, input logic [7:0] b);
        ph = p;
        nxt.send_valid = 1'b1;
        nxt.mosi = b;
    endfunction

    function logic [7:0] wire_cmd();
        return cur_cmd[7] ? CMD_APP : {1'b0, cur_cmd[6:0]};
    endfunction

    function logic [7:0] frame_byte(input logic [2:0] i);
        logic [7:0]  c;
        logic [31:0] a;
        c = wire_cmd();
        a = cur_cmd[7] ? 32'd0 : cur_arg;
        case (i)
            3'd0: return 8'h40 | c;
            3'd1: return a[31:24];
            3'd2: return a[23:16];
            3'd3: return a[15:8];
            3'd4: return a[7:0];
            default:
                if (c == CMD_GO_IDLE)
                    return 8'h95;
                else if (c == CMD_IF_COND)
                    return 8'h87;
                else
                    return 8'h01;
        endcase
    endfunction

    function void send_frame();
        frame_pos = 3'd0;
        issue(PH_FRAME, frame_byte(3'd0));
    endfunction

    // CMD0 and CMD12 go out without the select handshake
    function void begin_command();
        logic [7:0] c;
        c = wire_cmd();
        if (c != CMD_STOP && c != CMD_GO_IDLE)
        begin
            selected = 1'b0;
            issue(PH_DESEL, BYTE_IDLE);
        end
        else
            send_frame();
    endfunction

    function void close_out();
        selected = 1'b0;
        issue(PH_FINISH, BYTE_IDLE);
    endfunction

    function void blocks_done();
        if (cur_cmd == CMD_READN)
        begin
            cur_cmd = CMD_STOP;
            cur_arg = '0;
            begin_command();
        end
        else
            close_out();
    endfunction

    function void wait_token();
        if (tok_limit == '0)
            blocks_done();
        else
        begin
            tries_left = tok_limit;
            issue(PH_TOKEN, BYTE_IDLE);
        end
    endfunction

    function void init_clocks();
        selected = 1'b0;
        byte_pos = '0;
        issue(PH_INITCLK, BYTE_IDLE);
    endfunction

    function void send_acmd41();
        cur_cmd = CMD_ACMD41;
        cur_arg = ARG_HCS;
        begin_command();
    endfunction

    function void resume_request(input logic [7:0] r);
        logic [6:0] c;
        c = cur_cmd[6:0];
        if (kind == KIND_READ)
        begin
            if (cur_cmd == CMD_STOP)
            begin
                last_r1 = '0;
                close_out();
            end
            else if (r != 8'd0)
                close_out();
            else if (blocks_left == '0)
                blocks_done();
            else
                wait_token();
        end
        else if (kind == KIND_INIT)
        begin
            if (c == CMD_GO_IDLE[6:0])
            begin
                if (r == 8'd1)
                begin
                    cur_cmd = CMD_IF_COND;
                    cur_arg = ARG_IF_COND;
                    begin_command();
                end
                else
                begin
                    outer_left = outer_left - 16'd1;
                    if (outer_left == '0)
                        close_out();
                    else
                        init_clocks();
                end
            end
            else if (c == CMD_IF_COND[6:0])
            begin
                if (r != 8'd1)
                    close_out();
                else
                begin
                    byte_pos = '0;
                    issue(PH_R7, BYTE_IDLE);
                end
            end
            else if (r == 8'd0)
            begin
                div_now = div_bound(run_div);
                blocks_left = '0;
                close_out();
            end
            else
            begin
                outer_left = outer_left - 16'd1;
                if (outer_left == '0)
                    close_out();
                else
                    send_acmd41();
            end
        end
        else
        begin
            ph = PH_IDLE;
            nxt.done_res = 1'b1;
            nxt.response = r;
            nxt.ok = ~r[7];
        end
    endfunction

    // an app command whose CMD55 answer is 0 or 1 goes on with the command itself
    function void command_answered(input logic [7:0] r);
        last_r1 = r;
        if (cur_cmd[7] && r <= 8'd1)
        begin
            cur_cmd[7] = 1'b0;
            begin_command();
        end
        else
            resume_request(r);
    endfunction

    function void poll_r1();
        if (r1_limit == '0)
            command_answered(BYTE_IDLE);
        else
        begin
            tries_left = {9'd0, r1_limit};
            issue(PH_RESP, BYTE_IDLE);
        end
    endfunction

    function void on_exchange(input logic [7:0] miso);
        case (ph)
            PH_DESEL:
            begin
                selected = 1'b1;
                issue(PH_SELDUMMY, BYTE_IDLE);
            end
            PH_SELDUMMY:
                if (sel_limit == '0)
                begin
                    selected = 1'b0;
                    issue(PH_SELFAIL, BYTE_IDLE);
                end
                else
                begin
                    tries_left = {1'b0, sel_limit};
                    issue(PH_SELPOLL, BYTE_IDLE);
                end
            PH_SELPOLL:
                if (miso == BYTE_IDLE)
                    send_frame();
                else
                begin
                    tries_left = tries_left - 17'd1;
                    if (tries_left == '0)
                    begin
                        selected = 1'b0;
                        issue(PH_SELFAIL, BYTE_IDLE);
                    end
                    else
                        issue(PH_SELPOLL, BYTE_IDLE);
                end
            PH_SELFAIL:
                command_answered(BYTE_IDLE);
            PH_FRAME:
            begin
                frame_pos = frame_pos + 3'd1;
                if (frame_pos < 3'd6)
                    issue(PH_FRAME, frame_byte(frame_pos));
                else if (wire_cmd() == CMD_STOP)
                    issue(PH_STUFF, BYTE_IDLE);
                else
                    poll_r1();
            end
            PH_STUFF:
                poll_r1();
            PH_RESP:
            begin
                tries_left = tries_left - 17'd1;
                if (!miso[7] || tries_left == '0)
                    command_answered(miso);
                else
                    issue(PH_RESP, BYTE_IDLE);
            end
            PH_TOKEN:
                if (miso == TOKEN_DATA)
                begin
                    byte_pos = '0;
                    issue(PH_DATA, BYTE_IDLE);
                end
                else
                begin
                    tries_left = tries_left - 17'd1;
                    if (tries_left == '0)
                        blocks_done();
                    else
                        issue(PH_TOKEN, BYTE_IDLE);
                end
            PH_DATA:
            begin
                nxt.data_valid = 1'b1;
                nxt.data = miso;
                byte_pos = byte_pos + 10'd1;
                if (byte_pos >= BLOCK_BYTES)
                begin
                    nxt.last_of_block = 1'b1;
                    issue(PH_CRC1, BYTE_IDLE);
                end
                else
                    issue(PH_DATA, BYTE_IDLE);
            end
            PH_CRC1:
                issue(PH_CRC2, BYTE_IDLE);
            PH_CRC2:
            begin
                blocks_left = blocks_left - 16'd1;
                if (blocks_left == '0)
                    blocks_done();
                else
                    wait_token();
            end
            PH_INITCLK:
            begin
                byte_pos = byte_pos + 10'd1;
                if (byte_pos < 10'd10)
                    issue(PH_INITCLK, BYTE_IDLE);
                else
                begin
                    selected = 1'b1;
                    cur_cmd = CMD_GO_IDLE;
                    cur_arg = '0;
                    begin_command();
                end
            end
            PH_R7:
            begin
                byte_pos = byte_pos + 10'd1;
                if (byte_pos < 10'd4)
                    issue(PH_R7, BYTE_IDLE);
                else
                begin
                    outer_left = ready_limit;
                    if (outer_left == '0)
                        close_out();
                    else
                        send_acmd41();
                end
            end
            PH_FINISH:
            begin
                ph = PH_IDLE;
                nxt.done_res = 1'b1;
                nxt.response = last_r1;
                if (kind == KIND_READ)
                    nxt.ok = (blocks_left == '0 && last_r1 == 8'd0);
                else
                    nxt.ok = (blocks_left == '0);
            end
            default:
                ph = PH_IDLE;
        endcase
    endfunction

    function result_t engine_step(input logic [1:0] op, input logic [7:0] c,
                                  input logic [31:0] a, input logic [15:0] n,
                                  input logic [7:0] miso);
        nxt = '0;
        if (ph == PH_IDLE)
        begin
            if (op == OP_CMD)
            begin
                kind = KIND_CMD;
                cur_cmd = c;
                cur_arg = a;
                begin_command();
            end
            else if (op == OP_READ)
            begin
                kind = KIND_READ;
                blocks_left = n;
                cur_cmd = (n > 16'd1) ? CMD_READN : CMD_READ1;
                cur_arg = a;
                begin_command();
            end
            else if (op == OP_INIT)
            begin
                kind = KIND_INIT;
                div_now = div_bound(init_div);
                blocks_left = 16'd1;
                last_r1 = BYTE_IDLE;
                outer_left = idle_limit;
                if (outer_left == '0)
                    close_out();
                else
                    init_clocks();
            end
        end
        else if (op == OP_XCHG)
            on_exchange(miso);
        nxt.cs_low = selected;
        nxt.divider = div_now;
        return nxt;
    endfunction

    function void check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, e, a);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            sel_limit = 16'd500;
            tok_limit = 17'd100000;
            r1_limit = 8'd10;
            idle_limit = 16'd1000;
            ready_limit = 16'd1000;
            init_div = 9'd251;
            run_div = 9'd6;
            ph = PH_IDLE;
            kind = KIND_CMD;
            cur_cmd = '0;
            cur_arg = '0;
            frame_pos = '0;
            tries_left = '0;
            outer_left = '0;
            byte_pos = '0;
            blocks_left = '0;
            last_r1 = BYTE_IDLE;
            selected = 1'b0;
            div_now = 9'd251;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_SELECT: sel_limit = cfg_wdata[15:0];
                    REG_TOKEN:  tok_limit = cfg_wdata;
                    REG_RESP:   r1_limit = cfg_wdata[7:0];
                    REG_IDLE:   idle_limit = cfg_wdata[15:0];
                    REG_READY:  ready_limit = cfg_wdata[15:0];
                    REG_INITDV: init_div = cfg_wdata[8:0];
                    REG_RUNDV:  run_div = cfg_wdata[8:0];
                    default: ;
                endcase
            if (req.valid && req.ready)
                expected_results.push_back(engine_step(req.opcode, req.cmd, req.arg,
                                                       req.count, req.miso));
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result transaction with nothing expected");
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("send_valid", exp_r.send_valid, res.send_valid);
                    check_field("mosi", exp_r.mosi, res.mosi);
                    check_field("cs_low", exp_r.cs_low, res.cs_low);
                    check_field("data_valid", exp_r.data_valid, res.data_valid);
                    check_field("data", exp_r.data, res.data);
                    check_field("last_of_block", exp_r.last_of_block, res.last_of_block);
                    check_field("done_res", exp_r.done_res, res.done_res);
                    check_field("response", exp_r.response, res.response);
                    check_field("ok", exp_r.ok, res.ok);
                    check_field("divider", exp_r.divider, res.divider);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_sd_spi_command_engine.sv
// Testbench top: plays the card side of the SD SPI command engine and gives the verdict.
module tb_sd_spi_command_engine;
    import sdspi_pkg::*;

    localparam int STOP_ITEMS = 850;       // random part ends after this many accepted items
    localparam int CYCLE_LIMIT = 1000000;  // generous bound on the whole run

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_wdata;

    sdspi_req_if req_ch ();
    sdspi_res_if res_ch ();

    int mismatches;
    int pending;
    int items_sent;
    int results_seen;
    int requests_done;
    int cycles;
    int gap_pct;
    int stall_pct;
    int hold_cycles;
    bit no_token;     // card never sends the data start token

    sd_spi_command_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sdspi_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // count result transactions; done_res marks the end of a request
    always @(posedge clk)
    begin
        cycles++;
        if (res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (res_ch.done_res)
                requests_done++;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sd_spi_command_engine test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked for
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Card behavior: biased toward the bytes that move the sequence on
    // (0xFF ready, R1 of 0 or 1, 0xFE token), with some fully random bytes.
    function automatic logic [7:0] card_byte();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 35)
            b = BYTE_IDLE;
        else if (pick < 55)
            b = 8'h00;
        else if (pick < 70)
            b = 8'h01;
        else if (pick < 88)
            b = TOKEN_DATA;
        else
            b = 8'($urandom_range(255));
        if (no_token && b == TOKEN_DATA)
            b = 8'hFD;
        return b;
    endfunction

    // one request transaction; valid stays high afterwards, so offers are gap-free unless a random gap is drawn
    task automatic offer(input logic [1:0] op, input logic [7:0] c, input logic [31:0] a,
                         input logic [15:0] n, input logic [7:0] miso);
        // idling profile moves through three stages over the run
        if (items_sent < STOP_ITEMS / 3)
        begin
            gap_pct = 10;
            stall_pct = 78;
        end
        else if (items_sent < 2 * STOP_ITEMS / 3)
        begin
            gap_pct = 78;
            stall_pct = 10;
        end
        else
        begin
            gap_pct = 0;
            stall_pct = 0;
        end
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.cmd    <= c;
        req_ch.arg    <= a;
        req_ch.count  <= n;
        req_ch.miso   <= miso;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // drop valid, then wait until every result is back
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // issue a request, then answer exchanges until the engine reports done;
    // a few requests are thrown in mid-sequence, which the engine must ignore
    task automatic run_request(input logic [1:0] op, input logic [7:0] c, input logic [31:0] a,
                               input logic [15:0] n);
        int done_before;
        done_before = requests_done;
        offer(op, c, a, n, card_byte());
        while (requests_done == done_before)
        begin
            if ($urandom_range(99) < 2)
                offer(2'($urandom_range(2)), 8'($urandom_range(255)), $urandom(),
                      16'($urandom_range(2)), card_byte());
            else
                offer(OP_XCHG, 8'($urandom_range(255)), $urandom(),
                      16'($urandom_range(65535)), card_byte());
        end
    endtask

    task automatic set_registers(input logic [16:0] sel, input logic [16:0] tok,
                                 input logic [16:0] r1, input logic [16:0] idl,
                                 input logic [16:0] rdy, input logic [16:0] idv,
                                 input logic [16:0] rdv);
        logic [16:0] vals [7];
        vals = '{sel, tok, r1, idl, rdy, idv, rdv};
        drain();
        for (int i = 0; i < 7; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_cmd();
        case ($urandom_range(7))
            0: return CMD_GO_IDLE;
            1: return CMD_IF_COND;
            2: return CMD_STOP;
            3: return CMD_ACMD41;
            4: return CMD_APP;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        int reqs;
        int op_pick;
        logic [15:0] blocks;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_XCHG;
        req_ch.cmd = '0;
        req_ch.arg = '0;
        req_ch.count = '0;
        req_ch.miso = '0;
        res_ch.ready = 1'b0;
        items_sent = 0;
        results_seen = 0;
        requests_done = 0;
        cycles = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        no_token = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: exchange notice while idle is dropped; one command at reset values
        offer(OP_XCHG, 8'h00, 32'd0, 16'd0, 8'hFF);
        run_request(OP_CMD, CMD_READ1, 32'hFFFF_FFFF, 16'hFFFF);

        // moderate tries, extreme dividers
        set_registers(17'd20, 17'd40, 17'd8, 17'd30, 17'd30, 17'd2, 17'd256);
        run_request(OP_CMD, CMD_GO_IDLE, 32'd0, 16'd0);
        run_request(OP_CMD, CMD_IF_COND, 32'hFFFF_FFFF, 16'd0);
        run_request(OP_CMD, CMD_STOP, 32'h5A5A_A5A5, 16'd0);
        run_request(OP_CMD, CMD_ACMD41, ARG_HCS, 16'd0);
        run_request(OP_CMD, 8'hFF, $urandom(), 16'd0);
        run_request(OP_READ, 8'd0, 32'd0, 16'd0);
        // long receiver hold-off during a read: the engine fills and stalls its input
        hold_cycles = 300;
        run_request(OP_READ, 8'd0, 32'h0000_1234, 16'd1);
        run_request(OP_INIT, 8'd0, 32'd0, 16'd0);
        // count at its top: the token never comes, so the read times out and stops
        no_token = 1'b1;
        run_request(OP_READ, 8'd0, 32'h8000_0000, 16'hFFFF);
        no_token = 1'b0;

        // every limit at zero, dividers out of range
        set_registers(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd511);
        run_request(OP_CMD, CMD_READ1, 32'd7, 16'd0);
        run_request(OP_CMD, 8'h85, 32'd0, 16'd0);
        run_request(OP_CMD, CMD_STOP, 32'd0, 16'd0);
        run_request(OP_READ, 8'd0, 32'd9, 16'd1);
        run_request(OP_INIT, 8'd0, 32'd0, 16'd0);

        // every limit at its top
        set_registers(17'd65535, 17'd131071, 17'd255, 17'd65535, 17'd65535, 17'd256, 17'd2);
        run_request(OP_CMD, CMD_GO_IDLE, 32'd0, 16'd0);
        run_request(OP_READ, 8'd0, 32'd3, 16'd0);
        run_request(OP_INIT, 8'd0, 32'd0, 16'd0);

        // random part: registers change every dozen requests
        reqs = 0;
        while (items_sent < STOP_ITEMS)
        begin
            if (reqs % 12 == 0)
                set_registers(17'($urandom_range(40)), 17'($urandom_range(60)),
                              17'($urandom_range(20)), 17'($urandom_range(40)),
                              17'($urandom_range(40)), 17'($urandom_range(511)),
                              17'($urandom_range(511)));
            op_pick = $urandom_range(99);
            if (op_pick < 55)
                run_request(OP_CMD, pick_cmd(), $urandom(), 16'($urandom_range(65535)));
            else if (op_pick < 80)
                run_request(OP_INIT, 8'($urandom_range(255)), $urandom(),
                            16'($urandom_range(65535)));
            else if (op_pick < 95)
                run_request(OP_READ, 8'($urandom_range(255)), $urandom(), 16'd0);
            else
            begin
                // wide block count with the token withheld keeps the read short
                blocks = 16'($urandom_range(65535));
                no_token = 1'b1;
                run_request(OP_READ, 8'($urandom_range(255)), $urandom(), blocks);
                no_token = 1'b0;
            end
            reqs++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("sd_spi_command_engine test passed");
        else
            $display("sd_spi_command_engine test failed");
        $finish;
    end

endmodule
